// ===== sv/biu_pkg.sv =====
// ----------------------------------------------------------------------------
// biu_pkg: shared definitions for the bilinear image upscaler
// Widths, register indexes, the beat types passed between the front and the
// back, and the reciprocal tables used for division by the scale.
// ----------------------------------------------------------------------------
`default_nettype none

package biu_pkg;

  // Image store geometry
  localparam int MAX_SRC_DIM = 256;
  localparam int MAX_SCALE   = 16;
  localparam int DIM_W       = $clog2(MAX_SRC_DIM);
  localparam int ADDR_W      = 2 * DIM_W;
  localparam int MEM_DEPTH   = MAX_SRC_DIM * MAX_SRC_DIM;

  // Field widths
  localparam int COORD_W    = 12;
  localparam int PIX_W      = 8;
  localparam int VAL_W      = 16;
  localparam int SCALE_W    = 5;
  localparam int SIZE_W     = 9;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 9;

  // Coordinate division: fraction, weights and reciprocal
  localparam int FRAC_W    = $clog2(MAX_SCALE);
  localparam int WGT_W     = SCALE_W;
  localparam int WPROD_W   = 2 * FRAC_W + 1;
  localparam int REM_W     = SCALE_W + 1;
  localparam int RCP_SHIFT = COORD_W;
  localparam int RCP_W     = COORD_W + 1;

  // Final normalisation by scale squared
  localparam int SUM_W      = 16;
  localparam int X_W        = SUM_W + 8;
  localparam int DEN_W      = WPROD_W;
  localparam int RCP2_SHIFT = X_W;
  localparam int RCP2_W     = X_W + 1;
  localparam int RCP2_LO_W  = 13;
  localparam int RCP2_HI_W  = RCP2_W - RCP2_LO_W;
  localparam int REM2_W     = DEN_W + 1;

  // Queue and result buffer
  localparam int QDEPTH = 8;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = QPTR_W + 1;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_SCALE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ROWS  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_COLS  = 2'd2;

  // Item modes
  localparam logic MODE_WRITE = 1'b0;
  localparam logic MODE_READ  = 1'b1;

  // Effective configuration after clamping
  typedef struct packed {
    logic [SCALE_W-1:0] scale;
    logic [SIZE_W-1:0]  rows;
    logic [SIZE_W-1:0]  cols;
  } cfg_t;

  // Flags that travel with every item
  typedef struct packed {
    logic is_wr;
    logic err;
  } flg_t;

  // Classified item handed from the front to the back
  typedef struct packed {
    flg_t                flg;
    logic [DIM_W-1:0]    r0;
    logic [DIM_W-1:0]    c0;
    logic [DIM_W-1:0]    r1;
    logic [DIM_W-1:0]    c1;
    logic [WPROD_W-1:0]  w00;
    logic [WPROD_W-1:0]  w10;
    logic [WPROD_W-1:0]  w01;
    logic [WPROD_W-1:0]  w11;
    logic [PIX_W-1:0]    pixel;
    logic [DEN_W-1:0]    den;
    logic [RCP2_W-1:0]   rcp2;
  } item_t;

  // Result beat
  typedef struct packed {
    logic [VAL_W-1:0] value;
    logic             range_error;
  } result_t;

  // floor(4096 / s) for the scale range
  function automatic logic [RCP_W-1:0] rcp_coord(input logic [SCALE_W-1:0] s);
    logic [RCP_W-1:0] r;
    case (s)
      5'd2:    r = 13'd2048;
      5'd3:    r = 13'd1365;
      5'd4:    r = 13'd1024;
      5'd5:    r = 13'd819;
      5'd6:    r = 13'd682;
      5'd7:    r = 13'd585;
      5'd8:    r = 13'd512;
      5'd9:    r = 13'd455;
      5'd10:   r = 13'd409;
      5'd11:   r = 13'd372;
      5'd12:   r = 13'd341;
      5'd13:   r = 13'd315;
      5'd14:   r = 13'd292;
      5'd15:   r = 13'd273;
      5'd16:   r = 13'd256;
      default: r = 13'd4096;
    endcase
    return r;
  endfunction

  // floor(2^24 / s^2) for the scale range
  function automatic logic [RCP2_W-1:0] rcp_den(input logic [SCALE_W-1:0] s);
    logic [RCP2_W-1:0] r;
    case (s)
      5'd2:    r = 25'd4194304;
      5'd3:    r = 25'd1864135;
      5'd4:    r = 25'd1048576;
      5'd5:    r = 25'd671088;
      5'd6:    r = 25'd466033;
      5'd7:    r = 25'd342392;
      5'd8:    r = 25'd262144;
      5'd9:    r = 25'd207126;
      5'd10:   r = 25'd167772;
      5'd11:   r = 25'd138654;
      5'd12:   r = 25'd116508;
      5'd13:   r = 25'd99273;
      5'd14:   r = 25'd85598;
      5'd15:   r = 25'd74565;
      5'd16:   r = 25'd65536;
      default: r = 25'd16777216;
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== sv/biu_channels.sv =====
// ----------------------------------------------------------------------------
// biu_channels: handshake channels of the bilinear image upscaler
// Input item channel, result channel and configuration write channel.
// ----------------------------------------------------------------------------
`default_nettype none

interface biu_in_if;
  logic                         valid;
  logic                         ready;
  logic                         mode;
  logic [biu_pkg::COORD_W-1:0]  row;
  logic [biu_pkg::COORD_W-1:0]  col;
  logic [biu_pkg::PIX_W-1:0]    pixel;

  modport source (output valid, mode, row, col, pixel, input ready);
  modport sink   (input valid, mode, row, col, pixel, output ready);
endinterface

interface biu_out_if;
  logic                       valid;
  logic                       ready;
  logic [biu_pkg::VAL_W-1:0]  value;
  logic                       range_error;

  modport source (output valid, value, range_error, input ready);
  modport sink   (input valid, value, range_error, output ready);
endinterface

interface biu_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [biu_pkg::CFG_IDX_W-1:0]  index;
  logic [biu_pkg::CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

// ===== sv/biu_front.sv =====
// ----------------------------------------------------------------------------
// biu_front: item intake and classification
// Checks bounds, divides each coordinate by the scale through a reciprocal
// multiply with one correction step, and forms neighbour indexes and weights.
// ----------------------------------------------------------------------------
`default_nettype none

module biu_front (
  input  logic                        clk,
  input  logic                        rst_n,
  biu_in_if.sink                      in_ch,
  input  biu_pkg::cfg_t               cfg,
  input  logic [biu_pkg::QCNT_W-1:0]  q_count,
  output logic                        push,
  output biu_pkg::item_t              push_item
);

  localparam int LIM_W  = biu_pkg::SIZE_W + biu_pkg::SCALE_W;
  localparam int PRD_W  = biu_pkg::COORD_W + biu_pkg::RCP_W;
  localparam int MUL_W  = biu_pkg::COORD_W + biu_pkg::SCALE_W;
  localparam int CRD_W  = biu_pkg::QCNT_W + 1;

  // Stage 1: reciprocal products
  logic                          v1_r;
  biu_pkg::flg_t                 flg1_r;
  logic [biu_pkg::COORD_W-1:0]   row1_r, col1_r;
  logic [PRD_W-1:0]              prow1_r, pcol1_r;
  logic [biu_pkg::SCALE_W-1:0]   s1_r;
  logic [biu_pkg::PIX_W-1:0]     pix1_r;

  // Stage 2: estimated quotient and remainder
  logic                          v2_r;
  biu_pkg::flg_t                 flg2_r;
  logic [biu_pkg::COORD_W-1:0]   qr2_r, qc2_r;
  logic [biu_pkg::REM_W-1:0]     rr2_r, rc2_r;
  logic [biu_pkg::SCALE_W-1:0]   s2_r;
  logic [biu_pkg::PIX_W-1:0]     pix2_r;

  // Stage 3: base index and fraction
  logic                          v3_r;
  biu_pkg::flg_t                 flg3_r;
  logic [biu_pkg::DIM_W-1:0]     r03_r, c03_r;
  logic [biu_pkg::FRAC_W-1:0]    fr3_r, fc3_r;
  logic [biu_pkg::SCALE_W-1:0]   s3_r;
  logic [biu_pkg::PIX_W-1:0]     pix3_r;

  logic                          accept;
  logic [CRD_W-1:0]              fill;
  logic                          is_wr;
  logic [LIM_W-1:0]              lim_rows, lim_cols;
  logic                          err_wr, err_rd;
  logic [biu_pkg::SCALE_W-1:0]   div_s;
  logic [biu_pkg::RCP_W-1:0]     rcp;
  logic [biu_pkg::COORD_W-1:0]   qr, qc;
  logic [MUL_W-1:0]              dr, dc;
  logic                          fix_r, fix_c;
  logic [biu_pkg::COORD_W-1:0]   r0_fix, c0_fix;
  logic [biu_pkg::REM_W-1:0]     fr_fix, fc_fix;
  logic [biu_pkg::WGT_W-1:0]     wr0, wr1, wc0, wc1;
  logic [biu_pkg::SIZE_W-1:0]    r_inc, c_inc;

  // Space in the queue is reserved for every item still in the stages
  assign fill = CRD_W'(q_count) + CRD_W'(v1_r) + CRD_W'(v2_r) + CRD_W'(v3_r);
  assign in_ch.ready = (fill < CRD_W'(biu_pkg::QDEPTH));
  assign accept = in_ch.valid && in_ch.ready;

  // Bounds check and reciprocal lookup; a write divides by one
  always_comb begin
    is_wr    = (in_ch.mode == biu_pkg::MODE_WRITE);
    lim_rows = LIM_W'(cfg.rows) * LIM_W'(cfg.scale);
    lim_cols = LIM_W'(cfg.cols) * LIM_W'(cfg.scale);
    err_wr   = (in_ch.row >= biu_pkg::COORD_W'(cfg.rows)) ||
               (in_ch.col >= biu_pkg::COORD_W'(cfg.cols));
    err_rd   = (LIM_W'(in_ch.row) >= lim_rows) || (LIM_W'(in_ch.col) >= lim_cols);
    div_s    = is_wr ? biu_pkg::SCALE_W'(1) : cfg.scale;
    rcp      = biu_pkg::rcp_coord(div_s);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else begin
      v1_r <= accept;
    end
    flg1_r.is_wr <= is_wr;
    flg1_r.err   <= is_wr ? err_wr : err_rd;
    row1_r       <= in_ch.row;
    col1_r       <= in_ch.col;
    prow1_r      <= PRD_W'(in_ch.row) * PRD_W'(rcp);
    pcol1_r      <= PRD_W'(in_ch.col) * PRD_W'(rcp);
    s1_r         <= div_s;
    pix1_r       <= in_ch.pixel;
  end

  // Quotient estimate is low by at most one; remainder is below twice the scale
  always_comb begin
    qr = prow1_r[biu_pkg::RCP_SHIFT +: biu_pkg::COORD_W];
    qc = pcol1_r[biu_pkg::RCP_SHIFT +: biu_pkg::COORD_W];
    dr = MUL_W'(row1_r) - MUL_W'(qr) * MUL_W'(s1_r);
    dc = MUL_W'(col1_r) - MUL_W'(qc) * MUL_W'(s1_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else begin
      v2_r <= v1_r;
    end
    flg2_r <= flg1_r;
    qr2_r  <= qr;
    qc2_r  <= qc;
    rr2_r  <= dr[biu_pkg::REM_W-1:0];
    rc2_r  <= dc[biu_pkg::REM_W-1:0];
    s2_r   <= s1_r;
    pix2_r <= pix1_r;
  end

  // Correction step
  always_comb begin
    fix_r  = (rr2_r >= biu_pkg::REM_W'(s2_r));
    fix_c  = (rc2_r >= biu_pkg::REM_W'(s2_r));
    r0_fix = qr2_r + biu_pkg::COORD_W'(fix_r);
    c0_fix = qc2_r + biu_pkg::COORD_W'(fix_c);
    fr_fix = fix_r ? (rr2_r - biu_pkg::REM_W'(s2_r)) : rr2_r;
    fc_fix = fix_c ? (rc2_r - biu_pkg::REM_W'(s2_r)) : rc2_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r <= 1'b0;
    end else begin
      v3_r <= v2_r;
    end
    flg3_r <= flg2_r;
    r03_r  <= r0_fix[biu_pkg::DIM_W-1:0];
    c03_r  <= c0_fix[biu_pkg::DIM_W-1:0];
    fr3_r  <= fr_fix[biu_pkg::FRAC_W-1:0];
    fc3_r  <= fc_fix[biu_pkg::FRAC_W-1:0];
    s3_r   <= s2_r;
    pix3_r <= pix2_r;
  end

  // Wrapped neighbours, corner weights and the normalising reciprocal
  always_comb begin
    wr1   = biu_pkg::WGT_W'(fr3_r);
    wc1   = biu_pkg::WGT_W'(fc3_r);
    wr0   = s3_r - wr1;
    wc0   = s3_r - wc1;
    r_inc = biu_pkg::SIZE_W'(r03_r) + biu_pkg::SIZE_W'(1);
    c_inc = biu_pkg::SIZE_W'(c03_r) + biu_pkg::SIZE_W'(1);

    push_item.flg   = flg3_r;
    push_item.r0    = r03_r;
    push_item.c0    = c03_r;
    push_item.r1    = (r_inc == cfg.rows) ? '0 : r_inc[biu_pkg::DIM_W-1:0];
    push_item.c1    = (c_inc == cfg.cols) ? '0 : c_inc[biu_pkg::DIM_W-1:0];
    push_item.w00   = biu_pkg::WPROD_W'(wr0) * biu_pkg::WPROD_W'(wc0);
    push_item.w10   = biu_pkg::WPROD_W'(wr1) * biu_pkg::WPROD_W'(wc0);
    push_item.w01   = biu_pkg::WPROD_W'(wr0) * biu_pkg::WPROD_W'(wc1);
    push_item.w11   = biu_pkg::WPROD_W'(wr1) * biu_pkg::WPROD_W'(wc1);
    push_item.pixel = pix3_r;
    push_item.den   = biu_pkg::DEN_W'(s3_r) * biu_pkg::DEN_W'(s3_r);
    push_item.rcp2  = biu_pkg::rcp_den(s3_r);
  end

  assign push = v3_r;

endmodule

`default_nettype wire

// ===== sv/biu_queue.sv =====
// ----------------------------------------------------------------------------
// biu_queue: item queue between front and back
// Short first-in first-out buffer of classified items.
// ----------------------------------------------------------------------------
`default_nettype none

module biu_queue (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        push,
  input  biu_pkg::item_t              push_item,
  input  logic                        pop,
  output biu_pkg::item_t              head,
  output logic [biu_pkg::QCNT_W-1:0]  count
);

  biu_pkg::item_t               slot_r [biu_pkg::QDEPTH];
  logic [biu_pkg::QPTR_W-1:0]   wptr_r, wptr_nxt;
  logic [biu_pkg::QPTR_W-1:0]   rptr_r, rptr_nxt;
  logic [biu_pkg::QCNT_W-1:0]   cnt_r, cnt_nxt;

  // Pointer and fill bookkeeping
  always_comb begin
    wptr_nxt = push ? wptr_r + 1'b1 : wptr_r;
    rptr_nxt = pop ? rptr_r + 1'b1 : rptr_r;
    cnt_nxt  = cnt_r + biu_pkg::QCNT_W'(push) - biu_pkg::QCNT_W'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      wptr_r <= wptr_nxt;
      rptr_r <= rptr_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  // Storage
  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wptr_r] <= push_item;
    end
  end

  assign head  = slot_r[rptr_r];
  assign count = cnt_r;

endmodule

`default_nettype wire

// ===== sv/biu_back.sv =====
// ----------------------------------------------------------------------------
// biu_back: image store access and blending
// Writes source pixels, reads the four neighbours from two copies of the
// store, forms the weighted sum and divides by the scale squared.
// ----------------------------------------------------------------------------
`default_nettype none

module biu_back (
  input  logic                        clk,
  input  logic                        rst_n,
  input  biu_pkg::item_t              q_head,
  input  logic [biu_pkg::QCNT_W-1:0]  q_count,
  output logic                        pop,
  biu_out_if.source                   out_ch
);

  localparam int CRD_W  = biu_pkg::QCNT_W + 1;
  localparam int PP_W   = biu_pkg::PIX_W + biu_pkg::WPROD_W;
  localparam int ACC_W  = PP_W + 2;
  localparam int PLO_W  = biu_pkg::X_W + biu_pkg::RCP2_LO_W;
  localparam int PHI_W  = biu_pkg::X_W + biu_pkg::RCP2_HI_W;
  localparam int TOT_W  = biu_pkg::X_W + biu_pkg::RCP2_W;
  localparam int QD_W   = biu_pkg::VAL_W + biu_pkg::DEN_W;

  // Two copies of the image store, each one write and two reads per cycle
  logic [biu_pkg::PIX_W-1:0] mem_a [biu_pkg::MEM_DEPTH];
  logic [biu_pkg::PIX_W-1:0] mem_b [biu_pkg::MEM_DEPTH];

  logic [biu_pkg::ADDR_W-1:0] a00, a01, a10, a11;
  logic                       do_wr;

  // Stage 1: neighbour pixels
  logic                        v1_r;
  biu_pkg::flg_t               flg1_r;
  logic [biu_pkg::PIX_W-1:0]   p00_r, p01_r, p10_r, p11_r;
  logic [biu_pkg::WPROD_W-1:0] w00_r, w01_r, w10_r, w11_r;
  logic [biu_pkg::DEN_W-1:0]   den1_r;
  logic [biu_pkg::RCP2_W-1:0]  rcp21_r;

  // Stage 2: scaled weighted sum
  logic                        v2_r;
  biu_pkg::flg_t               flg2_r;
  logic [biu_pkg::X_W-1:0]     x2_r;
  logic [biu_pkg::DEN_W-1:0]   den2_r;
  logic [biu_pkg::RCP2_W-1:0]  rcp22_r;

  // Stage 3: reciprocal partial products
  logic                        v3_r;
  biu_pkg::flg_t               flg3_r;
  logic [biu_pkg::X_W-1:0]     x3_r;
  logic [biu_pkg::DEN_W-1:0]   den3_r;
  logic [PLO_W-1:0]            plo3_r;
  logic [PHI_W-1:0]            phi3_r;

  // Stage 4: quotient estimate
  logic                        v4_r;
  biu_pkg::flg_t               flg4_r;
  logic [biu_pkg::X_W-1:0]     x4_r;
  logic [biu_pkg::DEN_W-1:0]   den4_r;
  logic [biu_pkg::VAL_W-1:0]   q4_r;

  // Stage 5: remainder
  logic                        v5_r;
  biu_pkg::flg_t               flg5_r;
  logic [biu_pkg::DEN_W-1:0]   den5_r;
  logic [biu_pkg::VAL_W-1:0]   q5_r;
  logic [biu_pkg::REM2_W-1:0]  rem5_r;

  // Result buffer
  biu_pkg::result_t            ob_r [biu_pkg::QDEPTH];
  logic [biu_pkg::QPTR_W-1:0]  owp_r, owp_nxt;
  logic [biu_pkg::QPTR_W-1:0]  orp_r, orp_nxt;
  logic [biu_pkg::QCNT_W-1:0]  ocnt_r, ocnt_nxt;

  logic [CRD_W-1:0]            fill;
  logic [ACC_W-1:0]            acc;
  logic [TOT_W-1:0]            tot;
  logic [QD_W-1:0]             diff;
  logic                        fix;
  biu_pkg::result_t            res;
  logic                        opop;

  // Take an item only when the result buffer has room for everything in flight
  assign fill = CRD_W'(ocnt_r) + CRD_W'(v1_r) + CRD_W'(v2_r) + CRD_W'(v3_r)
              + CRD_W'(v4_r) + CRD_W'(v5_r);
  assign pop  = (q_count != '0) && (fill < CRD_W'(biu_pkg::QDEPTH));

  assign a00   = {q_head.r0, q_head.c0};
  assign a01   = {q_head.r0, q_head.c1};
  assign a10   = {q_head.r1, q_head.c0};
  assign a11   = {q_head.r1, q_head.c1};
  assign do_wr = pop && q_head.flg.is_wr && !q_head.flg.err;

  // Store writes and registered neighbour reads
  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem_a[a00] <= q_head.pixel;
      mem_b[a00] <= q_head.pixel;
    end
    if (pop) begin
      p00_r <= mem_a[a00];
      p01_r <= mem_a[a01];
      p10_r <= mem_b[a10];
      p11_r <= mem_b[a11];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else begin
      v1_r <= pop;
    end
    flg1_r  <= q_head.flg;
    w00_r   <= q_head.w00;
    w01_r   <= q_head.w01;
    w10_r   <= q_head.w10;
    w11_r   <= q_head.w11;
    den1_r  <= q_head.den;
    rcp21_r <= q_head.rcp2;
  end

  // Weighted sum of the four neighbours
  assign acc = ACC_W'(PP_W'(p00_r) * PP_W'(w00_r)) + ACC_W'(PP_W'(p10_r) * PP_W'(w10_r))
             + ACC_W'(PP_W'(p01_r) * PP_W'(w01_r)) + ACC_W'(PP_W'(p11_r) * PP_W'(w11_r));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else begin
      v2_r <= v1_r;
    end
    flg2_r  <= flg1_r;
    x2_r    <= {acc[biu_pkg::SUM_W-1:0], 8'd0};
    den2_r  <= den1_r;
    rcp22_r <= rcp21_r;
  end

  // Reciprocal multiply split in two partial products
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r <= 1'b0;
    end else begin
      v3_r <= v2_r;
    end
    flg3_r <= flg2_r;
    x3_r   <= x2_r;
    den3_r <= den2_r;
    plo3_r <= PLO_W'(x2_r) * PLO_W'(rcp22_r[biu_pkg::RCP2_LO_W-1:0]);
    phi3_r <= PHI_W'(x2_r) * PHI_W'(rcp22_r[biu_pkg::RCP2_W-1:biu_pkg::RCP2_LO_W]);
  end

  assign tot = (TOT_W'(phi3_r) << biu_pkg::RCP2_LO_W) + TOT_W'(plo3_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v4_r <= 1'b0;
    end else begin
      v4_r <= v3_r;
    end
    flg4_r <= flg3_r;
    x4_r   <= x3_r;
    den4_r <= den3_r;
    q4_r   <= tot[biu_pkg::RCP2_SHIFT +: biu_pkg::VAL_W];
  end

  // Remainder after the estimate stays below twice the divisor
  assign diff = QD_W'(x4_r) - QD_W'(q4_r) * QD_W'(den4_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v5_r <= 1'b0;
    end else begin
      v5_r <= v4_r;
    end
    flg5_r <= flg4_r;
    den5_r <= den4_r;
    q5_r   <= q4_r;
    rem5_r <= diff[biu_pkg::REM2_W-1:0];
  end

  // Final correction; writes and out-of-range items give zero
  always_comb begin
    fix             = (rem5_r >= biu_pkg::REM2_W'(den5_r));
    res.value       = (flg5_r.is_wr || flg5_r.err) ? '0
                    : q5_r + biu_pkg::VAL_W'(fix);
    res.range_error = flg5_r.err;
  end

  // Result buffer bookkeeping
  assign opop = out_ch.valid && out_ch.ready;

  always_comb begin
    owp_nxt  = v5_r ? owp_r + 1'b1 : owp_r;
    orp_nxt  = opop ? orp_r + 1'b1 : orp_r;
    ocnt_nxt = ocnt_r + biu_pkg::QCNT_W'(v5_r) - biu_pkg::QCNT_W'(opop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      owp_r  <= '0;
      orp_r  <= '0;
      ocnt_r <= '0;
    end else begin
      owp_r  <= owp_nxt;
      orp_r  <= orp_nxt;
      ocnt_r <= ocnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (v5_r) begin
      ob_r[owp_r] <= res;
    end
  end

  assign out_ch.valid       = (ocnt_r != '0);
  assign out_ch.value       = ob_r[orp_r].value;
  assign out_ch.range_error = ob_r[orp_r].range_error;

endmodule

`default_nettype wire

// ===== sv/bilinear_image_upscaler.sv =====
// ----------------------------------------------------------------------------
// bilinear_image_upscaler: integer-factor bilinear upscaler
// Holds the source image, takes pixel writes and answers output pixel
// requests in unsigned 8.8 fixed point.
// ----------------------------------------------------------------------------
//
//  Channel   Direction  Beat contents
//  in_ch     in         mode, row, col, pixel
//  out_ch    out        value, range_error
//  cfg_ch    in         index, data (scale, src_rows, src_cols)
//
// One item per cycle sustained while out_ch is ready; a result passes three
// front stages, the queue, five back stages and the result buffer.
// The rate is set by the image store: two copies, each serving two reads.
// Reset clears control state and sets scale 2 and a 256 x 256 source; the
// image store is not cleared. A stalled result side fills the eight-entry
// result buffer; in_ch.ready falls when queue and front stages hold eight.
// ----------------------------------------------------------------------------
`default_nettype none

module bilinear_image_upscaler (
  input  logic        clk,
  input  logic        rst_n,
  biu_in_if.sink      in_ch,
  biu_out_if.source   out_ch,
  biu_cfg_if.sink     cfg_ch
);

  logic [biu_pkg::SCALE_W-1:0] scale_r;
  logic [biu_pkg::SIZE_W-1:0]  rows_r;
  logic [biu_pkg::SIZE_W-1:0]  cols_r;
  biu_pkg::cfg_t               cfg_eff;

  logic                        q_push;
  logic                        q_pop;
  biu_pkg::item_t              q_in;
  biu_pkg::item_t              q_head;
  logic [biu_pkg::QCNT_W-1:0]  q_count;

  // Configuration registers
  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scale_r <= biu_pkg::SCALE_W'(2);
      rows_r  <= biu_pkg::SIZE_W'(biu_pkg::MAX_SRC_DIM);
      cols_r  <= biu_pkg::SIZE_W'(biu_pkg::MAX_SRC_DIM);
    end else if (cfg_ch.valid) begin
      case (cfg_ch.index)
        biu_pkg::CFG_SCALE: scale_r <= cfg_ch.data[biu_pkg::SCALE_W-1:0];
        biu_pkg::CFG_ROWS:  rows_r  <= cfg_ch.data;
        biu_pkg::CFG_COLS:  cols_r  <= cfg_ch.data;
        default: ;
      endcase
    end
  end

  // Clamp the registers to their working ranges
  always_comb begin
    if (scale_r == '0) begin
      cfg_eff.scale = biu_pkg::SCALE_W'(1);
    end else if (scale_r > biu_pkg::SCALE_W'(biu_pkg::MAX_SCALE)) begin
      cfg_eff.scale = biu_pkg::SCALE_W'(biu_pkg::MAX_SCALE);
    end else begin
      cfg_eff.scale = scale_r;
    end
    if (rows_r == '0) begin
      cfg_eff.rows = biu_pkg::SIZE_W'(1);
    end else if (rows_r > biu_pkg::SIZE_W'(biu_pkg::MAX_SRC_DIM)) begin
      cfg_eff.rows = biu_pkg::SIZE_W'(biu_pkg::MAX_SRC_DIM);
    end else begin
      cfg_eff.rows = rows_r;
    end
    if (cols_r == '0) begin
      cfg_eff.cols = biu_pkg::SIZE_W'(1);
    end else if (cols_r > biu_pkg::SIZE_W'(biu_pkg::MAX_SRC_DIM)) begin
      cfg_eff.cols = biu_pkg::SIZE_W'(biu_pkg::MAX_SRC_DIM);
    end else begin
      cfg_eff.cols = cols_r;
    end
  end

  // Front, queue and back
  biu_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .cfg       (cfg_eff),
    .q_count   (q_count),
    .push      (q_push),
    .push_item (q_in)
  );

  biu_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_item (q_in),
    .pop       (q_pop),
    .head      (q_head),
    .count     (q_count)
  );

  biu_back u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_head  (q_head),
    .q_count (q_count),
    .pop     (q_pop),
    .out_ch  (out_ch)
  );

  // The queue never overflows, never underflows and never overfills
  a_q_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    q_push |-> (q_count < biu_pkg::QCNT_W'(biu_pkg::QDEPTH)) || q_pop)
    else $error("item queue overflow");

  a_q_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> (q_count != '0))
    else $error("item queue popped while empty");

  a_q_bound: assert property (@(posedge clk) disable iff (!rst_n)
    q_count <= biu_pkg::QCNT_W'(biu_pkg::QDEPTH))
    else $error("item queue count beyond depth");

endmodule

`default_nettype wire
